// ===== rtl/nhl_pkg.sv =====
// ----------------------------------------------------------------------------
// nhl_pkg
// Types, codes and constants shared by the nibble handshake link.
// ----------------------------------------------------------------------------
package nhl_pkg;

	localparam int MAX_NIBBLES = 8;

	// mode codes of an input item
	localparam logic [2:0] MODE_SAMPLE = 3'd0;
	localparam logic [2:0] MODE_NIBBLE = 3'd1;
	localparam logic [2:0] MODE_BYTE   = 3'd2;
	localparam logic [2:0] MODE_HALF   = 3'd3;
	localparam logic [2:0] MODE_WORD   = 3'd4;
	localparam logic [2:0] MODE_SYNC   = 3'd5;

	localparam logic [4:0] STROBE_BIT = 5'h10;

	// sync pattern: what we send and what the peer must answer
	localparam logic [3:0] SYNC_TX [4] = '{4'h0, 4'hF, 4'hA, 4'hE};
	localparam logic [3:0] SYNC_RX [4] = '{4'hF, 4'h0, 4'hE, 4'hA};

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_RISE = 3'b010,
		PH_FALL = 3'b100
	} phase_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] send_value;
		logic        peer_strobe;
		logic [3:0]  peer_nibble;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  port_drive;
		logic [31:0] received_value;
		logic        transfer_done;
		logic        link_busy;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  nibbles_left;
		logic [31:0] send_shift;
		logic [31:0] receive_shift;
		logic        sync_active;
		logic [1:0]  sync_step;
		logic [4:0]  drive_reg;
	} link_state_t;

	localparam link_state_t STATE_RESET = '{
		phase:         PH_IDLE,
		nibbles_left:  4'd0,
		send_shift:    32'd0,
		receive_shift: 32'd0,
		sync_active:   1'b0,
		sync_step:     2'd0,
		drive_reg:     5'd0
	};

	// nibble count of a transfer mode, limited to MAX_NIBBLES and to 8
	function automatic logic [3:0] xfer_count(input logic [2:0] mode);
		int n;
		n = 1 << (int'(mode) - 1);
		if (n > MAX_NIBBLES)
			n = MAX_NIBBLES;
		if (n > 8)
			n = 8;
		if (n < 1)
			n = 1;
		return 4'(n);
	endfunction

	// left-align the low 4*n bits of the value
	function automatic logic [31:0] load_shift(input logic [31:0] value, input logic [3:0] n);
		logic [5:0] shamt;
		shamt = 6'(32 - 4 * int'(n));
		if (n >= 4'd8)
			return value;
		return value << shamt;
	endfunction

endpackage

// ===== rtl/nhl_step.sv =====
// ----------------------------------------------------------------------------
// nhl_step
// One handshake step: next link state and the result for one item.
// ----------------------------------------------------------------------------
module nhl_step (
	input  nhl_pkg::in_item_t    item,
	input  nhl_pkg::link_state_t cur,
	output nhl_pkg::link_state_t nxt,
	output nhl_pkg::out_item_t   result
);

	logic       busy;
	logic       done;
	logic [3:0] own_nib;
	logic [3:0] cnt;
	logic [3:0] left_dec;

	assign busy     = (cur.phase == nhl_pkg::PH_RISE) || (cur.phase == nhl_pkg::PH_FALL);
	assign own_nib  = cur.sync_active ? nhl_pkg::SYNC_TX[cur.sync_step] : cur.send_shift[31:28];
	assign cnt      = nhl_pkg::xfer_count(item.mode);
	assign left_dec = cur.nibbles_left - 4'd1;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		case (item.mode) inside
			nhl_pkg::MODE_SYNC: begin
				if (!busy) begin
					nxt.receive_shift = '0;
					nxt.phase         = nhl_pkg::PH_RISE;
					nxt.sync_active   = 1'b1;
					nxt.sync_step     = 2'd0;
					nxt.nibbles_left  = 4'd0;
					nxt.send_shift    = '0;
				end
			end
			nhl_pkg::MODE_NIBBLE, nhl_pkg::MODE_BYTE, nhl_pkg::MODE_HALF,
			nhl_pkg::MODE_WORD: begin
				if (!busy) begin
					nxt.receive_shift = '0;
					nxt.phase         = nhl_pkg::PH_RISE;
					nxt.sync_active   = 1'b0;
					nxt.sync_step     = 2'd0;
					nxt.nibbles_left  = cnt;
					nxt.send_shift    = nhl_pkg::load_shift(item.send_value, cnt);
				end
			end
			nhl_pkg::MODE_SAMPLE: begin
				if (cur.phase == nhl_pkg::PH_RISE) begin
					if (item.peer_strobe) begin
						nxt.receive_shift = {cur.receive_shift[27:0], item.peer_nibble};
						nxt.drive_reg     = {1'b0, own_nib} | nhl_pkg::STROBE_BIT;
						nxt.phase         = nhl_pkg::PH_FALL;
					end
				end else if (cur.phase == nhl_pkg::PH_FALL && !item.peer_strobe) begin
					nxt.drive_reg = '0;
					if (cur.sync_active) begin
						// last captured nibble sits in the low bits
						if (cur.receive_shift[3:0] != nhl_pkg::SYNC_RX[cur.sync_step]) begin
							nxt.sync_step     = 2'd0;
							nxt.receive_shift = '0;
							nxt.phase         = nhl_pkg::PH_RISE;
						end else if (cur.sync_step == 2'd3) begin
							nxt.sync_step   = 2'd0;
							nxt.sync_active = 1'b0;
							nxt.phase       = nhl_pkg::PH_IDLE;
							done            = 1'b1;
						end else begin
							nxt.sync_step = cur.sync_step + 2'd1;
							nxt.phase     = nhl_pkg::PH_RISE;
						end
					end else begin
						nxt.send_shift   = {cur.send_shift[27:0], 4'h0};
						nxt.nibbles_left = left_dec;
						if (left_dec == 4'd0) begin
							nxt.phase = nhl_pkg::PH_IDLE;
							done      = 1'b1;
						end else begin
							nxt.phase = nhl_pkg::PH_RISE;
						end
					end
				end
			end
			default: begin
				// unused modes leave the state alone
			end
		endcase
	end

	assign result.port_drive     = nxt.drive_reg;
	assign result.received_value = nxt.receive_shift;
	assign result.transfer_done  = done;
	assign result.link_busy      = (nxt.phase == nhl_pkg::PH_RISE)
	                             || (nxt.phase == nhl_pkg::PH_FALL);

endmodule

// ===== rtl/nibble_handshake_link.sv =====
// ----------------------------------------------------------------------------
// nibble_handshake_link
// Full-duplex nibble link with a strobe handshake, one step per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item): start items (1, 2, 4 or 8
// nibbles, or sync) and link samples of the peer port. Each sample works
// one handshake step. Output channel (out_valid/out_ready/out_item): one
// result per input item, in order: the port value to drive, the nibbles
// received so far, a done flag and the busy flag.
// The step logic sits between the input register and the result register.
// Throughput: one item per clock when not stalled; the link state lives in
// a single register updated by one pass of the step logic, so a sample can
// follow every cycle. A stalled receiver holds the result register; the
// input register then fills and in_ready drops until the result is taken.
// Reset (arst_n low) empties both registers, returns the link to idle and
// clears the drive value and the receive shift register.
// ----------------------------------------------------------------------------
module nibble_handshake_link (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nhl_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output nhl_pkg::out_item_t  out_item
);

	nhl_pkg::in_item_t    item_s1;
	logic                 valid_s1;
	nhl_pkg::link_state_t state_q;
	nhl_pkg::link_state_t state_nxt;
	nhl_pkg::out_item_t   result;
	nhl_pkg::out_item_t   out_q;
	logic                 out_valid_q;
	logic                 advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	nhl_step u_step (
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= nhl_pkg::STATE_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1)
					state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
		if (advance && valid_s1)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== rtl/nhl_checker.sv =====
// ----------------------------------------------------------------------------
// nhl_checker
// Port-level checks on the result channel of the nibble handshake link.
// ----------------------------------------------------------------------------
module nhl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input nhl_pkg::out_item_t out_item
);

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// a finished transfer leaves the link idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.transfer_done |-> !out_item.link_busy)
		else $error("done item still reports busy");

	// completion happens on the strobe fall, so the port is released
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.transfer_done |-> out_item.port_drive == 5'd0)
		else $error("port still driven on completion");

	// an own nibble is only ever driven together with the strobe
	a_drive_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.port_drive != 5'd0 |-> out_item.port_drive[4])
		else $error("nibble driven without strobe");

endmodule

bind nibble_handshake_link nhl_checker u_nhl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
